/* hdl/prt_pkg.sv */
// ----------------------------------------------------------------------------
// prt_pkg
// Types, codes and helpers shared by the pending request tracker.
// ----------------------------------------------------------------------------
package prt_pkg;

	typedef enum logic [1:0] {
		REQ_REGISTER = 2'd0,
		REQ_COMPLETE = 2'd1,
		REQ_EXPIRE   = 2'd2,
		REQ_CLEAR    = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		STS_OK          = 3'd0,
		STS_NONE        = 3'd1,
		STS_FULL        = 3'd2,
		STS_BAD_TIMEOUT = 3'd3,
		STS_CLEARED     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_EVAL,
		ST_CHK,
		ST_ADV,
		ST_FIN,
		ST_EMIT
	} state_t;

	// one table entry as held in the entry memory
	typedef struct packed {
		logic        [31:0] tag;
		logic        [15:0] channel;
		logic signed [63:0] created;
		logic signed [31:0] limit;
	} entry_t;

	// one result word
	typedef struct packed {
		status_t            status;
		logic        [31:0] corr_id;
		logic        [15:0] chan;
		logic signed [63:0] created_ms;
		logic signed [31:0] limit_ms;
		logic               last;
	} res_t;

	function automatic res_t res_of_entry(input entry_t e, input logic last);
		res_t r;
		r.status     = STS_OK;
		r.corr_id    = e.tag;
		r.chan       = e.channel;
		r.created_ms = e.created;
		r.limit_ms   = e.limit;
		r.last       = last;
		return r;
	endfunction

	function automatic res_t res_empty(input status_t s);
		res_t r;
		r.status     = s;
		r.corr_id    = 32'd0;
		r.chan       = 16'd0;
		r.created_ms = 64'sd0;
		r.limit_ms   = 32'sd0;
		r.last       = 1'b1;
		return r;
	endfunction

	// tag counter skips zero
	function automatic logic [31:0] tag_take(input logic [31:0] w);
		return (w == 32'd0) ? 32'd1 : w;
	endfunction

	function automatic logic [31:0] tag_after(input logic [31:0] w);
		return (w == 32'd0) ? 32'd2 : w + 32'd1;
	endfunction

endpackage

/* hdl/prt_entry_ram.sv */
// ----------------------------------------------------------------------------
// prt_entry_ram
// Entry storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module prt_entry_ram
	import prt_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  entry_t                     wr_data,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	output entry_t                     rd_data
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

/* hdl/pending_request_tracker_unit.sv */
// ----------------------------------------------------------------------------
// pending_request_tracker_unit
// Keeps up to DEPTH outstanding requests keyed by nonzero 32-bit tags and
// serves register, complete, expire and clear words one at a time. Entry
// contents sit in a single-port-read memory that is swept slot by slot:
// read, evaluate, then advance, with a check step before the advance for
// expire. Valid bits are flops and clear at reset. Clear and a rejected
// timeout go straight to the result. Complete with a nonzero tag sweeps
// until it finds the tag. Register sweeps once per tag candidate, with one
// extra candidate sweep for each candidate tag already pending (at most
// DEPTH sweeps). Expire sweeps once and emits each expired entry but the
// last during the sweep. Result port stalls lengthen every operation. The
// registered read port sets these steps. A new word is taken only in the idle state.
module pending_request_tracker_unit
	import prt_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [1:0]         req_type,
	input  logic [15:0]        req_chan,
	input  logic signed [63:0] now_ms,
	input  logic signed [31:0] req_limit,
	input  logic [31:0]        corr_id,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [2:0]         res_status,
	output logic [31:0]        res_corr_id,
	output logic [15:0]        res_channel_id,
	output logic signed [63:0] res_created_ms,
	output logic signed [31:0] res_timeout_ms,
	output logic               res_last
);

	localparam int IW = $clog2(DEPTH);

	state_t             state_q, state_d;
	state_t             ret_q, ret_d;
	logic [DEPTH-1:0]   valid_q;
	logic [IW-1:0]      idx_q;
	logic [IW-1:0]      free_idx_q;
	logic               free_found_q;
	logic               hit_q;
	logic               held_valid_q;
	logic [31:0]        next_tag_q;
	logic               out_valid_q;

	req_t               op_q;
	logic [15:0]        ch_q;
	logic signed [63:0] now_q;
	logic signed [31:0] tmo_q;
	logic [31:0]        cid_q;
	logic [31:0]        cand_q;
	logic [31:0]        work_q;
	logic [64:0]        diff_q;
	res_t               pend_q;
	res_t               held_q;
	res_t               out_q;

	entry_t             rd_entry;
	entry_t             wr_entry;
	logic               wr_en;

	logic               req_fire;
	logic               out_free;
	logic               is_last_idx;
	logic               slot_valid;
	logic               bad_tmo;
	logic               cmp_match;
	logic               expired;
	res_t               held_fin;

	assign req_ready   = (state_q == ST_IDLE);
	assign req_fire    = req_valid && req_ready;
	assign out_free    = !out_valid_q || res_ready;
	assign is_last_idx = (idx_q == IW'(DEPTH - 1));
	assign slot_valid  = valid_q[idx_q];
	assign bad_tmo     = req_limit[31] && (req_limit != -32'sd1);
	assign cmp_match   = slot_valid && (rd_entry.tag == cid_q);

	// exact now - created is nonnegative and reaches the limit
	assign expired = slot_valid && !rd_entry.limit[31] && !diff_q[64]
		&& (diff_q[63:0] >= {32'd0, rd_entry.limit});

	always_comb begin
		held_fin      = held_q;
		held_fin.last = 1'b1;
	end

	assign wr_en    = (state_q == ST_FIN) && (op_q == REQ_REGISTER)
		&& free_found_q && !hit_q;
	assign wr_entry = '{tag: cand_q, channel: ch_q, created: now_q, limit: tmo_q};

	prt_entry_ram #(
		.DEPTH(DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (free_idx_q),
		.wr_data (wr_entry),
		.rd_addr (idx_q),
		.rd_data (rd_entry)
	);

	// next state
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					if (req_t'(req_type) == REQ_CLEAR
						|| (req_t'(req_type) == REQ_REGISTER && bad_tmo)) begin
						state_d = ST_EMIT;
						ret_d   = ST_IDLE;
					end else if (req_t'(req_type) == REQ_COMPLETE && corr_id == 32'd0) begin
						state_d = ST_FIN;
					end else begin
						state_d = ST_RD;
					end
				end
			end
			ST_RD: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (op_q == REQ_EXPIRE) begin
					state_d = ST_CHK;
				end else if (op_q == REQ_COMPLETE && cmp_match) begin
					state_d = ST_EMIT;
					ret_d   = ST_IDLE;
				end else begin
					state_d = ST_ADV;
				end
			end
			ST_CHK: begin
				if (expired && held_valid_q) begin
					state_d = ST_EMIT;
					ret_d   = ST_ADV;
				end else begin
					state_d = ST_ADV;
				end
			end
			ST_ADV: begin
				state_d = is_last_idx ? ST_FIN : ST_RD;
			end
			ST_FIN: begin
				if (op_q == REQ_REGISTER && free_found_q && hit_q) begin
					state_d = ST_RD;
				end else begin
					state_d = ST_EMIT;
					ret_d   = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ret_q;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			idx_q        <= '0;
			free_found_q <= 1'b0;
			hit_q        <= 1'b0;
			held_valid_q <= 1'b0;
			next_tag_q   <= 32'd1;
			out_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						idx_q        <= '0;
						free_found_q <= 1'b0;
						hit_q        <= 1'b0;
						held_valid_q <= 1'b0;
						if (req_t'(req_type) == REQ_CLEAR) begin
							valid_q <= '0;
						end
					end
				end
				ST_EVAL: begin
					if (op_q == REQ_REGISTER) begin
						if (!slot_valid) begin
							free_found_q <= 1'b1;
						end
						if (slot_valid && rd_entry.tag == cand_q) begin
							hit_q <= 1'b1;
						end
					end else if (op_q == REQ_COMPLETE && cmp_match) begin
						valid_q[idx_q] <= 1'b0;
					end
				end
				ST_CHK: begin
					if (expired) begin
						valid_q[idx_q] <= 1'b0;
						held_valid_q   <= 1'b1;
					end
				end
				ST_ADV: begin
					if (!is_last_idx) begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_FIN: begin
					if (op_q == REQ_REGISTER && free_found_q) begin
						if (hit_q) begin
							// candidate already pending: sweep again with the next one
							idx_q <= '0;
							hit_q <= 1'b0;
						end else begin
							valid_q[free_idx_q] <= 1'b1;
							next_tag_q          <= work_q;
							free_found_q        <= 1'b0;
						end
					end
					held_valid_q <= 1'b0;
				end
				default: begin
				end
			endcase

			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					op_q   <= req_t'(req_type);
					ch_q   <= req_chan;
					now_q  <= now_ms;
					tmo_q  <= req_limit;
					cid_q  <= corr_id;
					cand_q <= tag_take(next_tag_q);
					work_q <= tag_after(next_tag_q);
					pend_q <= (req_t'(req_type) == REQ_CLEAR) ? res_empty(STS_CLEARED)
						: res_empty(STS_BAD_TIMEOUT);
				end
			end
			ST_EVAL: begin
				if (op_q == REQ_REGISTER && !slot_valid && !free_found_q) begin
					free_idx_q <= idx_q;
				end
				if (op_q == REQ_COMPLETE && cmp_match) begin
					pend_q <= res_of_entry(rd_entry, 1'b1);
				end
				diff_q <= {now_q[63], now_q} - {rd_entry.created[63], rd_entry.created};
			end
			ST_CHK: begin
				if (expired) begin
					held_q <= res_of_entry(rd_entry, 1'b0);
					if (held_valid_q) begin
						pend_q <= held_q;
					end
				end
			end
			ST_FIN: begin
				case (op_q)
					REQ_REGISTER: begin
						if (!free_found_q) begin
							pend_q <= res_empty(STS_FULL);
						end else if (hit_q) begin
							cand_q <= tag_take(work_q);
							work_q <= tag_after(work_q);
						end else begin
							pend_q <= res_of_entry(wr_entry, 1'b1);
						end
					end
					REQ_EXPIRE: begin
						pend_q <= held_valid_q ? held_fin : res_empty(STS_NONE);
					end
					default: begin
						pend_q <= res_empty(STS_NONE);
					end
				endcase
			end
			ST_EMIT: begin
				if (out_free) begin
					out_q <= pend_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res_valid      = out_valid_q;
	assign res_status     = out_q.status;
	assign res_corr_id    = out_q.corr_id;
	assign res_channel_id = out_q.chan;
	assign res_created_ms = out_q.created_ms;
	assign res_timeout_ms = out_q.limit_ms;
	assign res_last       = out_q.last;

	// only expire can leave a word without the last mark
	a_last_single: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && op_q != REQ_EXPIRE) |-> pend_q.last)
		else $error("non-expire result without last mark");

	// the recorded free slot stays free while the candidate sweep runs
	a_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(op_q == REQ_REGISTER && free_found_q
			&& (state_q == ST_RD || state_q == ST_EVAL || state_q == ST_ADV))
		|-> !valid_q[free_idx_q])
		else $error("free slot taken during tag sweep");

	// every returned entry carries a nonzero tag
	a_tag_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == STS_OK) |-> (out_q.corr_id != 32'd0))
		else $error("entry result with zero tag");

	// a held expire word never outlives its operation
	a_held_expire: assert property (@(posedge clk) disable iff (!arst_n)
		held_valid_q |-> (op_q == REQ_EXPIRE && state_q != ST_IDLE))
		else $error("held word outside expire");

	// a register result commits the tag counter one past the tag handed out
	a_tag_commit: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (next_tag_q == $past(work_q)))
		else $error("tag counter not committed");

endmodule

/* tb/pending_request_tracker_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pending_request_tracker_unit_tb
// The testbench keeps its own copy of the request table and tag counter and
// predicts every result word for each accepted request. It checks the result
// words in order, field by field. A directed opening covers bad timeouts,
// tag zero, time extremes, a full table and a fifteen-entry expire. Random
// traffic follows, with fill-and-expire bursts, idle bursts on both sides
// and one long result stall that backs up the request side.
// ----------------------------------------------------------------------------
module pending_request_tracker_unit_tb;
	import prt_pkg::*;

	localparam int DEPTH        = 16;
	localparam int ITEMS        = 360;
	localparam int QUIET_TAIL   = 60;
	localparam int HOLD_AT      = 150;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 3 * DEPTH + 8;

	localparam logic signed [63:0] T_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] T_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [31:0] TMO_NEVER = -32'sd1;
	localparam logic signed [31:0] TMO_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] TMO_MIN   = 32'sh8000_0000;

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_ready;
	logic [1:0]         req_type;
	logic [15:0]        req_chan;
	logic signed [63:0] now_ms;
	logic signed [31:0] req_limit;
	logic [31:0]        corr_id;
	logic               res_valid;
	logic               res_ready;
	logic [2:0]         res_status;
	logic [31:0]        res_corr_id;
	logic [15:0]        res_channel_id;
	logic signed [63:0] res_created_ms;
	logic signed [31:0] res_timeout_ms;
	logic               res_last;

	pending_request_tracker_unit #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_type(req_type),
		.req_chan(req_chan),
		.now_ms(now_ms),
		.req_limit(req_limit),
		.corr_id(corr_id),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_status(res_status),
		.res_corr_id(res_corr_id),
		.res_channel_id(res_channel_id),
		.res_created_ms(res_created_ms),
		.res_timeout_ms(res_timeout_ms),
		.res_last(res_last)
	);

	// table of outstanding requests plus the result words still owed
	class pending_table_model;
		bit          busy[DEPTH];
		entry_t      slot_q[DEPTH];
		logic [31:0] tag_ctr;
		res_t        owed_q[$];
		int          n_errors;
		int          n_words;
		int          n_results;
		int          n_expired;
		int          n_full;
		int          n_bad;

		function new();
			foreach (busy[i]) begin
				busy[i] = 1'b0;
			end
			tag_ctr   = 32'd1;
			n_errors  = 0;
			n_words   = 0;
			n_results = 0;
			n_expired = 0;
			n_full    = 0;
			n_bad     = 0;
		endfunction

		function res_t blank(status_t s);
			res_t r;
			r.status     = s;
			r.corr_id    = '0;
			r.chan       = '0;
			r.created_ms = '0;
			r.limit_ms   = '0;
			r.last       = 1'b1;
			return r;
		endfunction

		function res_t from_slot(int s, logic fin);
			res_t r;
			r.status     = STS_OK;
			r.corr_id    = slot_q[s].tag;
			r.chan       = slot_q[s].channel;
			r.created_ms = slot_q[s].created;
			r.limit_ms   = slot_q[s].limit;
			r.last       = fin;
			return r;
		endfunction

		function bit tag_busy(logic [31:0] t);
			for (int i = 0; i < DEPTH; i++) begin
				if (busy[i] && slot_q[i].tag == t)
					return 1'b1;
			end
			return 1'b0;
		endfunction

		// exact difference, a creation time in the future never runs out
		function bit ran_out(int s, logic signed [63:0] now);
			logic signed [64:0] age;
			if (slot_q[s].limit < 0)
				return 1'b0;
			age = {now[63], now} - {slot_q[s].created[63], slot_q[s].created};
			return (age >= 65'sd0) && (age >= $signed({33'd0, slot_q[s].limit}));
		endfunction

		function int occupancy();
			int cnt;
			cnt = 0;
			foreach (busy[i]) begin
				if (busy[i])
					cnt++;
			end
			return cnt;
		endfunction

		function bit pick_pending(output logic [31:0] t);
			int pick;
			t = '0;
			if (occupancy() == 0)
				return 1'b0;
			pick = $urandom_range(0, occupancy() - 1);
			foreach (busy[i]) begin
				if (busy[i]) begin
					if (pick == 0) begin
						t = slot_q[i].tag;
						return 1'b1;
					end
					pick--;
				end
			end
			return 1'b0;
		endfunction

		function void note_word(req_t kind, logic [15:0] ch, logic signed [63:0] now,
				logic signed [31:0] tmo, logic [31:0] cid);
			int          slot;
			int          hits;
			logic [31:0] cand;
			n_words++;
			case (kind)
				REQ_REGISTER: begin
					slot = -1;
					for (int i = 0; i < DEPTH; i++) begin
						if (!busy[i] && slot < 0)
							slot = i;
					end
					if (tmo < -32'sd1) begin
						owed_q = {owed_q, blank(STS_BAD_TIMEOUT)};
						n_bad++;
					end else if (slot < 0) begin
						owed_q = {owed_q, blank(STS_FULL)};
						n_full++;
					end else begin
						cand = '0;
						for (int k = 0; k < DEPTH + 2; k++) begin
							cand = tag_ctr;
							tag_ctr++;
							if (cand == 32'd0) begin
								cand = tag_ctr;
								tag_ctr++;
							end
							if (!tag_busy(cand))
								break;
						end
						busy[slot]           = 1'b1;
						slot_q[slot].tag     = cand;
						slot_q[slot].channel = ch;
						slot_q[slot].created = now;
						slot_q[slot].limit   = tmo;
						owed_q = {owed_q, from_slot(slot, 1'b1)};
					end
				end
				REQ_COMPLETE: begin
					slot = -1;
					if (cid != 32'd0) begin
						for (int i = 0; i < DEPTH; i++) begin
							if (busy[i] && slot_q[i].tag == cid && slot < 0)
								slot = i;
						end
					end
					if (slot >= 0) begin
						busy[slot] = 1'b0;
						owed_q = {owed_q, from_slot(slot, 1'b1)};
					end else begin
						owed_q = {owed_q, blank(STS_NONE)};
					end
				end
				REQ_EXPIRE: begin
					hits = 0;
					for (int i = 0; i < DEPTH; i++) begin
						if (busy[i] && ran_out(i, now)) begin
							busy[i] = 1'b0;
							owed_q = {owed_q, from_slot(i, 1'b0)};
							hits++;
						end
					end
					if (hits == 0)
						owed_q = {owed_q, blank(STS_NONE)};
					else
						owed_q[owed_q.size() - 1].last = 1'b1;
					n_expired += hits;
				end
				default: begin
					foreach (busy[i]) begin
						busy[i] = 1'b0;
					end
					owed_q = {owed_q, blank(STS_CLEARED)};
				end
			endcase
		endfunction

		task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
			n_errors++;
			$display("mismatch at result %0d: %s got %h want %h", n_results, what, got,
				want);
		endtask

		task check_word(res_t got);
			res_t want;
			if (owed_q.size() == 0) begin
				report_mismatch("result word with nothing owed, tag", 64'(got.corr_id), 64'd0);
			end else begin
				want = owed_q.pop_front();
				if (got.status != want.status)
					report_mismatch("status", 64'(got.status), 64'(want.status));
				if (got.corr_id != want.corr_id)
					report_mismatch("corr_id", 64'(got.corr_id), 64'(want.corr_id));
				if (got.chan != want.chan)
					report_mismatch("channel", 64'(got.chan), 64'(want.chan));
				if (got.created_ms != want.created_ms)
					report_mismatch("created_ms", got.created_ms, want.created_ms);
				if (got.limit_ms != want.limit_ms)
					report_mismatch("timeout", 64'(got.limit_ms), 64'(want.limit_ms));
				if (got.last != want.last)
					report_mismatch("last", 64'(got.last), 64'(want.last));
			end
			n_results++;
		endtask
	endclass

	pending_table_model tracker_ref;
	res_t               seen_res;
	int                 words_sent;
	int                 idle_run;
	bit                 quiet_tail;
	bit                 recv_hold;
	bit                 hold_done;
	logic signed [63:0] clock_ms;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// the word is handed to the model at the edge where it is taken
	task automatic offer_word(req_t kind, logic [15:0] ch, logic signed [63:0] now,
			logic signed [31:0] tmo, logic [31:0] cid);
		req_valid <= 1'b1;
		req_type  <= kind;
		req_chan  <= ch;
		now_ms    <= now;
		req_limit <= tmo;
		corr_id   <= cid;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		tracker_ref.note_word(kind, ch, now, tmo, cid);
		words_sent++;
	endtask

	task automatic sender_pause();
		int n;
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 19);
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send(req_t kind, logic [15:0] ch, logic signed [63:0] now,
			logic signed [31:0] tmo, logic [31:0] cid);
		offer_word(kind, ch, now, tmo, cid);
		sender_pause();
	endtask

	task automatic random_word();
		int                 roll;
		req_t               kind;
		logic [31:0]        cid;
		logic signed [63:0] now;
		logic signed [31:0] tmo;
		clock_ms = clock_ms + 64'($urandom_range(0, 40));
		if ($urandom_range(0, 99) < 3)
			clock_ms = {$urandom, $urandom};
		if ($urandom_range(0, 19) == 0)
			now = {$urandom, $urandom};
		else
			now = clock_ms + 64'($urandom_range(0, 20));
		roll = $urandom_range(0, 99);
		if (roll < 45)
			kind = REQ_REGISTER;
		else if (roll < 72)
			kind = REQ_COMPLETE;
		else if (roll < 96)
			kind = REQ_EXPIRE;
		else
			kind = REQ_CLEAR;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			tmo = $urandom_range(0, 80);
		else if (roll < 65)
			tmo = TMO_NEVER;
		else if (roll < 78)
			tmo = $urandom >> 1;
		else if (roll < 90)
			tmo = $urandom;
		else
			tmo = -32'sd2 - $signed(32'($urandom_range(0, 1000)));
		cid = $urandom;
		if (kind == REQ_COMPLETE) begin
			if ($urandom_range(0, 3) != 0) begin
				if (!tracker_ref.pick_pending(cid))
					cid = $urandom_range(0, 40);
			end else if ($urandom_range(0, 2) == 0) begin
				cid = '0;
			end
		end
		send(kind, 16'($urandom_range(0, 65535)), now, tmo, cid);
	endtask

	// fill every free slot with short timeouts, overrun once, then sweep
	task automatic fill_and_expire();
		while (tracker_ref.occupancy() < DEPTH) begin
			clock_ms = clock_ms + 64'($urandom_range(0, 3));
			send(REQ_REGISTER, 16'($urandom_range(0, 65535)), clock_ms, $urandom_range(0, 5),
				$urandom);
		end
		send(REQ_REGISTER, 16'($urandom_range(0, 65535)), clock_ms, $urandom_range(0, 5),
			$urandom);
		clock_ms = clock_ms + 64'sd100;
		send(REQ_EXPIRE, 16'($urandom_range(0, 65535)), clock_ms, $urandom, $urandom);
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			seen_res.status     = status_t'(res_status);
			seen_res.corr_id    = res_corr_id;
			seen_res.chan       = res_channel_id;
			seen_res.created_ms = res_created_ms;
			seen_res.limit_ms   = res_timeout_ms;
			seen_res.last       = res_last;
			tracker_ref.check_word(seen_res);
		end
	end

	// result side, with one long hold-off while requests keep coming
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (recv_hold) begin
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				recv_hold = 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 2) == 0) begin
				res_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				res_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (res_valid && res_ready))
			idle_run <= 0;
		else
			idle_run <= idle_run + 1;
	end

	initial begin
		while (idle_run < STALL_LIMIT)
			@(posedge clk);
		$display("Verification failed");
		$finish;
	end

	initial begin
		logic [31:0] held_tag;
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		req_type   = REQ_REGISTER;
		req_chan   = '0;
		now_ms     = '0;
		req_limit  = '0;
		corr_id    = '0;
		res_ready  = 1'b0;
		quiet_tail = 1'b0;
		recv_hold  = 1'b0;
		hold_done  = 1'b0;
		words_sent = 0;
		clock_ms   = '0;
		tracker_ref = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, tag zero, unknown tag, rejected timeouts
		send(REQ_EXPIRE, 16'd0, 64'sd0, 32'sd0, 32'd0);
		send(REQ_COMPLETE, 16'd0, 64'sd0, 32'sd0, 32'd0);
		send(REQ_COMPLETE, 16'hFFFF, T_MAX, TMO_MIN, 32'hFFFF_FFFF);
		send(REQ_REGISTER, 16'h00FF, 64'sd5, -32'sd2, 32'd0);
		send(REQ_REGISTER, 16'd0, T_MIN, TMO_MIN, 32'd0);
		// time and timeout extremes
		send(REQ_REGISTER, 16'hFFFF, T_MAX, TMO_NEVER, 32'd0);
		send(REQ_REGISTER, 16'd0, T_MIN, 32'sd0, 32'd0);
		send(REQ_REGISTER, 16'h1234, T_MIN, TMO_MAX, 32'd0);
		send(REQ_REGISTER, 16'h8001, T_MAX, 32'sd0, 32'd0);
		// zero age at the minimum, then the widest age there is
		send(REQ_EXPIRE, 16'd0, T_MIN, 32'sd0, 32'd0);
		send(REQ_EXPIRE, 16'd0, T_MAX, 32'sd0, 32'd0);
		// full table, then one sweep that empties all but the never entry
		while (tracker_ref.occupancy() < DEPTH)
			send(REQ_REGISTER, 16'($urandom_range(0, 65535)), 64'sd0, 32'sd0, $urandom);
		send(REQ_REGISTER, 16'h5A5A, 64'sd0, 32'sd0, 32'd0);
		send(REQ_EXPIRE, 16'd0, 64'sd10, 32'sd0, 32'd0);
		void'(tracker_ref.pick_pending(held_tag));
		send(REQ_COMPLETE, 16'd0, 64'sd0, 32'sd0, held_tag);
		send(REQ_COMPLETE, 16'd0, 64'sd0, 32'sd0, held_tag);
		send(REQ_REGISTER, 16'h0042, 64'sd7, 32'sd100, 32'd0);
		void'(tracker_ref.pick_pending(held_tag));
		send(REQ_CLEAR, 16'd0, 64'sd0, 32'sd0, 32'd0);
		send(REQ_COMPLETE, 16'd0, 64'sd0, 32'sd0, held_tag);

		while (words_sent < ITEMS) begin
			quiet_tail = (words_sent >= ITEMS - QUIET_TAIL);
			if (!hold_done && words_sent >= HOLD_AT) begin
				recv_hold = 1'b1;
				hold_done = 1'b1;
			end
			if (!quiet_tail && $urandom_range(0, 99) < 8)
				fill_and_expire();
			else
				random_word();
		end
		req_valid <= 1'b0;

		while (tracker_ref.owed_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker_ref.owed_q.size() != 0)
			tracker_ref.report_mismatch("words still owed", 64'(tracker_ref.owed_q.size()),
				64'd0);

		$display("%0d request words, %0d result words checked", tracker_ref.n_words,
			tracker_ref.n_results);
		$display("%0d entries expired, %0d full-table and %0d bad-timeout rejects",
			tracker_ref.n_expired, tracker_ref.n_full, tracker_ref.n_bad);
		if (tracker_ref.n_errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
